FILE: hw/rtl/bm3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm3_pkg
// Shared constants, codes and the control struct of the 3x3 binary
// morphology block.
// ----------------------------------------------------------------------------
package bm3_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int FW_W       = 12;   // frame_width register
  localparam int FH_W       = 13;   // frame_height register

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam int FW_RESET = 640;
  localparam int FH_RESET = 480;
  localparam int MIN_SIZE = 3;

  // item kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // mode register values
  localparam logic MODE_DILATE = 1'b0;
  localparam logic MODE_ERODE  = 1'b1;

  // line store keeps a ring of four rows per column
  localparam int SLOTS  = 4;
  localparam int SLOT_W = 2;

  localparam int TDATA_W = 8;

  // per-cycle control from the scheduler to the window datapath
  typedef struct packed {
    logic              arrive;   // pixel written this cycle
    logic              pixel;
    logic [SLOT_W-1:0] aslot;    // row slot of the arriving pixel
    logic              emit;     // a result leaves this cycle
    logic [SLOT_W-1:0] oslot;    // row slot of the centre pixel
    logic              hit_l;    // arriving pixel lands in left column
    logic              hit_m;    // ... in the centre column
    logic              hit_r;    // ... in the right column
    logic              fwd_hit;  // write goes to the column being read
    logic              av_mr;    // middle-right neighbour has arrived
    logic              av_bl;    // bottom-left neighbour has arrived
    logic              av_bm;    // bottom-middle neighbour has arrived
    logic              av_br;    // bottom-right neighbour has arrived
    logic              row_up;   // row above is interior
    logic              row_mid;  // centre row is interior
    logic              row_dn;   // row below is interior
    logic              col_lf;   // left column is interior
    logic              col_md;   // centre column is interior
    logic              col_rt;   // right column is interior
    logic              erode;
    logic              last;     // centre is the final pixel of the frame
  } win_ctl_t;

endpackage

FILE: hw/rtl/bm3_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm3_ram
// Generic simple dual-port RAM: one write port with per-bit enables, one
// read port with registered (read-first) output.
// ----------------------------------------------------------------------------
module bm3_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic [WIDTH-1:0]         wr_mask,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIDTH; i++) begin
      if (wr_mask[i]) begin
        mem[wr_addr][i] <= wr_data[i];
      end
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/bm3_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm3_cfg
// Configuration registers. Frame sizes are clamped to their legal range as
// they are written; a size write restarts the frame.
// ----------------------------------------------------------------------------
module bm3_cfg
  import bm3_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [CFG_DATA_W-1:0]               cfg_data,
  output logic                                mode,
  output logic [$clog2(MAX_WIDTH+1)-1:0]      eff_w,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]     eff_h,
  output logic                                restart
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RST_W = (FW_RESET > MAX_WIDTH) ? MAX_WIDTH : FW_RESET;
  localparam int RST_H = (FH_RESET > MAX_HEIGHT) ? MAX_HEIGHT : FH_RESET;

  function automatic logic [WW-1:0] clamp_w(input logic [FW_W-1:0] v);
    logic [WW-1:0] o;
    if (32'(v) < 32'(MIN_SIZE)) o = WW'(MIN_SIZE);
    else if (32'(v) > 32'(MAX_WIDTH)) o = WW'(MAX_WIDTH);
    else o = WW'(v);
    return o;
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [FH_W-1:0] v);
    logic [HW-1:0] o;
    if (32'(v) < 32'(MIN_SIZE)) o = HW'(MIN_SIZE);
    else if (32'(v) > 32'(MAX_HEIGHT)) o = HW'(MAX_HEIGHT);
    else o = HW'(v);
    return o;
  endfunction

  // frame restarts on any size write
  assign restart = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_DILATE;
      eff_w <= WW'(RST_W);
      eff_h <= HW'(RST_H);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode  <= cfg_data[0];
        REG_WIDTH:  eff_w <= clamp_w(cfg_data[FW_W-1:0]);
        REG_HEIGHT: eff_h <= clamp_h(cfg_data[FH_W-1:0]);
        default: ;  // unmapped index: ignored
      endcase
    end
  end

endmodule

FILE: hw/rtl/bm3_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm3_sched
// Position tracking: arrival column and row slot, centre position of the
// next result, pending count, and the per-cycle control for the window.
// ----------------------------------------------------------------------------
module bm3_sched
  import bm3_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                operation,
  input  logic                                pixel,
  input  logic                                mode,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]     eff_h,
  input  logic                                restart,
  output win_ctl_t                            ctl,
  output logic [$clog2(MAX_WIDTH)-1:0]        waddr,
  output logic [$clog2(MAX_WIDTH)-1:0]        raddr
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = $clog2(MAX_WIDTH + 3);

  // arrival side
  logic [CW-1:0]     acol;
  logic [SLOT_W-1:0] aslot;
  // result side: centre column and its neighbours, row in frame, row slot
  logic [CW-1:0]     lcol, ocol, rcol;
  logic [RW-1:0]     orow;
  logic [SLOT_W-1:0] oslot;
  logic [PW-1:0]     pend;

  logic [CW-1:0] w_m1, w_m2;
  logic [RW-1:0] h_m1, h_m2;
  logic [PW-1:0] wp, pn;
  logic          arrive, emit;
  logic          a_wrap, o_wrap;
  logic [CW-1:0] rcol_inc, rcol_next;

  assign w_m1 = CW'(eff_w - WW'(1));
  assign w_m2 = CW'(eff_w - WW'(2));
  assign h_m1 = RW'(eff_h - HW'(1));
  assign h_m2 = RW'(eff_h - HW'(2));
  assign wp   = PW'(eff_w);

  // pending count including a pixel arriving now
  assign arrive = accept && (operation == OP_PIXEL);
  assign pn     = pend + PW'(arrive);

  assign emit = accept && ((arrive && (pn > wp + PW'(1))) ||
                           ((operation == OP_DRAIN) && (pend != '0)));

  assign a_wrap   = (acol == w_m1);
  assign o_wrap   = (ocol == w_m1);
  assign rcol_inc = (rcol == w_m1) ? '0 : rcol + CW'(1);

  always_comb begin
    if (restart) rcol_next = CW'(1);
    else if (emit) rcol_next = rcol_inc;
    else rcol_next = rcol;
  end

  assign waddr = acol;
  assign raddr = rcol_next;

  // control for the window datapath
  always_comb begin
    ctl.arrive  = arrive;
    ctl.pixel   = pixel;
    ctl.aslot   = aslot;
    ctl.emit    = emit;
    ctl.oslot   = oslot;
    ctl.hit_l   = arrive && (acol == lcol);
    ctl.hit_m   = arrive && (acol == ocol);
    ctl.hit_r   = arrive && (acol == rcol);
    ctl.fwd_hit = arrive && (acol == rcol_next);
    ctl.av_mr   = (pn >= PW'(2));
    ctl.av_bl   = (pn >= wp);
    ctl.av_bm   = (pn > wp);
    ctl.av_br   = (pn > wp + PW'(1));
    ctl.row_up  = (orow != '0) && (orow != RW'(1));
    ctl.row_mid = (orow != '0) && (orow != h_m1);
    ctl.row_dn  = (orow != h_m1) && (orow != h_m2);
    ctl.col_lf  = (ocol != '0) && (ocol != CW'(1));
    ctl.col_md  = (ocol != '0) && (ocol != w_m1);
    ctl.col_rt  = (ocol != w_m1) && (ocol != w_m2);
    ctl.erode   = (mode == MODE_ERODE);
    ctl.last    = (orow == h_m1) && o_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      acol  <= '0;
      aslot <= '0;
      lcol  <= '0;
      ocol  <= '0;
      rcol  <= CW'(1);
      orow  <= '0;
      oslot <= '0;
      pend  <= '0;
    end else begin
      pend <= pn - PW'(emit);
      if (arrive) begin
        acol <= a_wrap ? '0 : acol + CW'(1);
        if (a_wrap) aslot <= aslot + SLOT_W'(1);
      end
      // window slides one column per result
      if (emit) begin
        lcol <= ocol;
        ocol <= rcol;
        rcol <= rcol_inc;
        if (o_wrap) begin
          oslot <= oslot + SLOT_W'(1);
          orow  <= (orow == h_m1) ? '0 : orow + RW'(1);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend <= wp + PW'(1))
    else $error("pending count beyond one row plus one");

  a_col_ring: assert property (@(posedge clk) disable iff (rst)
    rcol == (o_wrap ? '0 : ocol + CW'(1)))
    else $error("right column out of step with centre column");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    restart |=> (pend == '0) && (ocol == '0) && (orow == '0) && (acol == '0))
    else $error("frame restart did not clear position state");
`endif

endmodule

FILE: hw/rtl/bm3_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm3_window
// Line store and 3x3 window. The store holds four row slots per column;
// the right window column is read from it every cycle, the centre and left
// columns are registers. Arriving pixels are patched into all three.
// ----------------------------------------------------------------------------
module bm3_window
  import bm3_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  win_ctl_t                      ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0]  waddr,
  input  logic [$clog2(MAX_WIDTH)-1:0]  raddr,
  output logic                          res
);

  logic [SLOTS-1:0]  rd_data;
  logic [SLOTS-1:0]  wr_mask;
  logic [SLOTS-1:0]  lcolw, mcolw;
  logic [SLOTS-1:0]  r_fwd, r_p, m_p, l_p;
  logic              lw_hit;
  logic [SLOT_W-1:0] lw_slot;
  logic              lw_pix;
  logic [SLOT_W-1:0] su, sm, sd;
  logic [2:0][2:0]   nb;
  logic [2:0]        rin, cin;
  logic              dil;

  function automatic logic [SLOTS-1:0] patch(input logic [SLOTS-1:0] col,
                                            input logic hit,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic pix);
    logic [SLOTS-1:0] o;
    o = col;
    if (hit) o[slot] = pix;
    return o;
  endfunction

  // one bit per row slot, written without a read
  assign wr_mask = ctl.arrive ? (SLOTS'(1) << ctl.aslot) : '0;

  bm3_ram #(
    .WIDTH (SLOTS),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_mask (wr_mask),
    .wr_addr (waddr),
    .wr_data ({SLOTS{ctl.pixel}}),
    .rd_addr (raddr),
    .rd_data (rd_data)
  );

  // right column: read data, last cycle's write forwarded, this cycle's write
  assign r_fwd = patch(rd_data, lw_hit, lw_slot, lw_pix);
  assign r_p   = patch(r_fwd, ctl.hit_r, ctl.aslot, ctl.pixel);
  assign m_p   = patch(mcolw, ctl.hit_m, ctl.aslot, ctl.pixel);
  assign l_p   = patch(lcolw, ctl.hit_l, ctl.aslot, ctl.pixel);

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_hit <= 1'b0;
    end else begin
      lw_hit <= ctl.fwd_hit;
    end
  end

  always_ff @(posedge clk) begin
    lw_slot <= ctl.aslot;
    lw_pix  <= ctl.pixel;
    if (ctl.emit) begin
      lcolw <= m_p;
      mcolw <= r_p;
    end else begin
      lcolw <= l_p;
      mcolw <= m_p;
    end
  end

  // 3x3 neighbourhood; pixels not yet arrived read as 0
  always_comb begin
    su = ctl.oslot - SLOT_W'(1);
    sm = ctl.oslot;
    sd = ctl.oslot + SLOT_W'(1);
    nb[0][0] = l_p[su];
    nb[0][1] = m_p[su];
    nb[0][2] = r_p[su];
    nb[1][0] = l_p[sm];
    nb[1][1] = m_p[sm];
    nb[1][2] = r_p[sm] & ctl.av_mr;
    nb[2][0] = l_p[sd] & ctl.av_bl;
    nb[2][1] = m_p[sd] & ctl.av_bm;
    nb[2][2] = r_p[sd] & ctl.av_br;
  end

  assign rin = {ctl.row_dn, ctl.row_mid, ctl.row_up};
  assign cin = {ctl.col_rt, ctl.col_md, ctl.col_lf};

  // dilation: only interior neighbours spread
  always_comb begin
    dil = nb[1][1];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        dil = dil | (nb[i][j] & rin[i] & cin[j]);
      end
    end
  end

  // erosion acts on interior pixels only
  always_comb begin
    if (ctl.erode) begin
      res = (rin[1] && cin[1]) ? (&nb) : nb[1][1];
    end else begin
      res = dil;
    end
  end

`ifndef SYNTHESIS
  a_fwd_src: assert property (@(posedge clk) disable iff (rst)
    lw_hit |-> $past(ctl.arrive))
    else $error("forwarding without a preceding line store write");
`endif

endmodule

FILE: hw/rtl/binary_morphology_3x3_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_morphology_3x3_top
// 3x3 binary dilation / erosion over a raster-order pixel stream.
// ----------------------------------------------------------------------------
// One item is accepted per clock, pixel or drain, while the skid stage is
// empty: the line store is read every cycle and written for each pixel, and
// the result is formed in the cycle of the item that releases it. A pixel's
// result leaves width+1 pixels after it arrives; drain items release the
// pending results one per item at the end of a frame. A result goes to an
// output register backed by a one-item skid stage, so the input keeps
// flowing while one result waits downstream. The line store needs no
// clearing pass after reset: pixels not yet received are masked out.
module binary_morphology_3x3_top
  import bm3_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,   // [0] pixel
  input  logic                  s_axis_tuser,   // [0] operation
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // [0] result_pixel
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH);

  logic          mode, restart, accept, res;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [CW-1:0] waddr, raddr;
  win_ctl_t      ctl;

  logic out_valid, out_pix, out_last;
  logic skid_valid, skid_pix, skid_last;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bm3_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .restart   (restart)
  );

  bm3_sched #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_sched (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (s_axis_tuser),
    .pixel     (s_axis_tdata[0]),
    .mode      (mode),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .restart   (restart),
    .ctl       (ctl),
    .waddr     (waddr),
    .raddr     (raddr)
  );

  bm3_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .waddr (waddr),
    .raddr (raddr),
    .res   (res)
  );

  // output register with skid stage: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= ctl.emit;
      end
    end else if (ctl.emit) begin
      skid_valid <= 1'b1;
    end
  end

  // output register with skid stage: payload
  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_pix  <= skid_pix;
        out_last <= skid_last;
      end else if (ctl.emit) begin
        out_pix  <= res;
        out_last <= ctl.last;
      end
    end else if (ctl.emit) begin
      skid_pix  <= res;
      skid_last <= ctl.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(TDATA_W-1)'(0), out_pix};
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds an item while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_axis_tready && ctl.emit))
    else $error("skid stage filled without a stalled output");
`endif

endmodule

FILE: tb/tb_binary_morphology_3x3_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_morphology_3x3_top
// Self-checking bench for the 3x3 binary dilation / erosion block. A
// scoreboard class keeps its own line ring, window position and register
// copy, works out each result pixel as input items are accepted, and checks
// the output stream field by field. Stimulus is a few hand-made frames and
// then random frames over many frame sizes, modes and traffic patterns.
// ----------------------------------------------------------------------------
module tb_binary_morphology_3x3_top;
  import bm3_pkg::*;

  localparam int MAX_W        = 2048;
  localparam int MAX_H        = 4096;
  localparam int RING         = 2 * MAX_W + 4;
  localparam int ITEMS_TARGET = 1750;
  localparam int SETTLE       = 8;       // cycles for items that release nothing
  localparam int SETTLE_END   = 32;
  localparam int LONG_HOLD    = 300;     // receiver hold-off, in cycles
  localparam int TIMEOUT_NS   = 5_000_000;

  // spare register index, not decoded by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic result_pixel;
    logic last_of_frame;
  } morph_out_t;

  // --------------------------------------------------------------------------
  // Scoreboard: pixel ring, frame position and the queue of expected pixels
  // --------------------------------------------------------------------------
  class morph_scoreboard;
    logic            ring_px [RING];
    int              wr_ptr;
    int              pend;       // pixels accepted, result not yet produced
    int              out_idx;    // raster index of the next result
    logic            mode;
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    morph_out_t      expected_pixels [$];
    int              errors;

    function new();
      foreach (ring_px[i]) ring_px[i] = 1'b0;
      mode       = MODE_DILATE;
      width_reg  = FW_RESET;
      height_reg = FH_RESET;
      errors     = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      wr_ptr  = 0;
      pend    = 0;
      out_idx = 0;
    endfunction

    function int eff_width();
      if (width_reg < MIN_SIZE) return MIN_SIZE;
      if (width_reg > MAX_W) return MAX_W;
      return int'(width_reg);
    endfunction

    function int eff_height();
      if (height_reg < MIN_SIZE) return MIN_SIZE;
      if (height_reg > MAX_H) return MAX_H;
      return int'(height_reg);
    endfunction

    // size writes restart the frame and drop whatever is pending
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MODE: mode = val[0];
        REG_WIDTH: begin
          width_reg = val[FW_W-1:0];
          restart_frame();
        end
        REG_HEIGHT: begin
          height_reg = val[FH_W-1:0];
          restart_frame();
        end
        default: ;
      endcase
    endfunction

    // pixel at raster offset d from the oldest pending one; 0 outside the
    // frame or when it has not arrived yet
    function logic px_at(int nr, int nc, int d, int w, int h);
      int idx;
      if (nr < 0 || nr >= h || nc < 0 || nc >= w) return 1'b0;
      if (d >= pend) return 1'b0;
      idx = (wr_ptr + 2 * RING - pend + d) % RING;
      return ring_px[idx];
    endfunction

    function bit interior(int r, int c, int w, int h);
      return r >= 1 && r <= h - 2 && c >= 1 && c <= w - 2;
    endfunction

    function morph_out_t next_pixel();
      morph_out_t o;
      int         w, h, total, r, c;
      logic       acc;
      w     = eff_width();
      h     = eff_height();
      total = w * h;
      if (out_idx >= total) out_idx = 0;
      r   = out_idx / w;
      c   = out_idx % w;
      acc = px_at(r, c, 0, w, h);
      if (mode == MODE_DILATE) begin
        // only interior neighbours spread
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            if ((dr != 0 || dc != 0) && interior(r + dr, c + dc, w, h))
              acc |= px_at(r + dr, c + dc, dr * w + dc, w, h);
      end else if (interior(r, c, w, h)) begin
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            acc &= px_at(r + dr, c + dc, dr * w + dc, w, h);
      end
      o.result_pixel  = acc;
      o.last_of_frame = (out_idx == total - 1);
      out_idx = o.last_of_frame ? 0 : out_idx + 1;
      pend--;
      return o;
    endfunction

    // returns 1 when the item is not simply ignored by the block
    function bit note_item(logic op, logic px);
      if (op == OP_PIXEL) begin
        ring_px[wr_ptr] = px;
        wr_ptr = (wr_ptr + 1) % RING;
        pend++;
        if (pend > eff_width() + 1) expected_pixels.push_back(next_pixel());
        return 1'b1;
      end
      if (pend > 0) begin
        expected_pixels.push_back(next_pixel());
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_result(logic res, logic last);
      morph_out_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: expected none, actual pixel=%b last=%b",
                 $time, res, last);
        return;
      end
      want = expected_pixels.pop_front();
      if (res !== want.result_pixel) begin
        errors++;
        $display("%0t: result_pixel mismatch: expected %b, actual %b",
                 $time, want.result_pixel, res);
      end
      if (last !== want.last_of_frame) begin
        errors++;
        $display("%0t: last_of_frame mismatch: expected %b, actual %b",
                 $time, want.last_of_frame, last);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, signals and the block
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata = '0;   // [0] pixel
  logic                  s_axis_tuser = 1'b0; // [0] operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;        // [0] result_pixel
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  morph_scoreboard sb = new();

  int gap_pct       = 0;
  int stall_pct     = 0;
  bit calm          = 1'b0;   // no idling on either side
  bit long_hold_req = 1'b0;
  int items_done    = 0;

  always #5 clk = ~clk;

  binary_morphology_3x3_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata[0], m_axis_tlast);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks; each is entered and left at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_item(input logic op, input logic px);
    int gap;
    if (!calm && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(TDATA_W - 1){1'b0}}, px};
    do @(posedge clk); while (!s_axis_tready);
    if (sb.note_item(op, px)) items_done++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    sb.write_reg(idx, CFG_DATA_W'(val));
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // all expected pixels out, then let trailing items settle
  task automatic wait_idle(input int settle);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  task automatic send_pixels(input int n_px, input int density);
    for (int i = 0; i < n_px; i++) begin
      // occasional drain in mid-frame breaks the sequence
      if ($urandom_range(99) < 4) send_item(OP_DRAIN, $urandom_range(0, 1));
      send_item(OP_PIXEL, $urandom_range(99) < density);
    end
  endtask

  // one random phase: registers, a run of frames, an optional flush
  task automatic run_phase(input int k);
    int   w_val, h_val, r, n_px, frames, n_drain, density, weff, heff;
    logic mode_val;
    w_val = -1;
    h_val = -1;
    // first phases walk the register extremes
    case (k)
      0: begin w_val = MAX_W; h_val = MIN_SIZE; end
      1: begin w_val = 4095;  h_val = 8191;     end
      2: begin w_val = 0;     h_val = 0;        end
      3: begin w_val = 1;     h_val = MAX_H;    end
      4: begin w_val = 2;     h_val = 2;        end
      5: begin w_val = 3;     h_val = 4;        end
      default: begin
        r = $urandom_range(0, 15);
        if (r < 10) w_val = $urandom_range(3, 10);
        else if (r == 10) w_val = $urandom_range(0, 2);
        else if (r == 11) w_val = MAX_W;
        else if (r == 12) w_val = $urandom_range(11, 64);
        else if (r == 13) w_val = FW_RESET;
        r = $urandom_range(0, 13);
        if (r < 10) h_val = $urandom_range(3, 8);
        else if (r == 10) h_val = $urandom_range(0, 2);
        else if (r == 11) h_val = MAX_H;
        else if (r == 12) h_val = $urandom_range(9, 40);
      end
    endcase
    mode_val = $urandom_range(0, 1) ? MODE_ERODE : MODE_DILATE;
    write_reg(REG_MODE, mode_val);
    if (w_val >= 0) write_reg(REG_WIDTH, w_val);
    if (h_val >= 0) write_reg(REG_HEIGHT, h_val);
    if (k == 2 || $urandom_range(0, 7) == 0) write_reg(REG_SPARE, $urandom_range(0, 8191));

    gap_pct   = pick_pct();
    stall_pct = pick_pct();
    case ($urandom_range(0, 2))
      0:       density = 10;
      1:       density = 50;
      default: density = 90;
    endcase
    weff = sb.eff_width();
    heff = sb.eff_height();
    if (weff <= 64 && heff <= 16) begin
      frames = $urandom_range(1, 3);
      if (weff * heff * frames > 400) frames = 1;
      n_px = weff * heff * frames;
    end else if (weff <= 64) begin
      n_px = $urandom_range(weff + 20, weff + 80);
    end else begin
      n_px = $urandom_range(20, 80);
    end

    // long receiver hold-off while the sender keeps offering items
    if (k == 5) begin
      n_px = 48;
      long_hold_req = 1'b1;
    end
    send_pixels(n_px, density);

    // flush the tail, or leave it pending for the next phase
    if ($urandom_range(0, 3) != 0) begin
      n_drain = sb.pend + $urandom_range(0, 2);
      for (int i = 0; i < n_drain; i++) send_item(OP_DRAIN, $urandom_range(0, 1));
    end
    wait_idle(SETTLE);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int k;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: drain on an empty block, then a drain in mid-frame
    send_item(OP_DRAIN, 1'b1);
    send_item(OP_PIXEL, 1'b1);
    send_item(OP_DRAIN, 1'b0);
    send_item(OP_DRAIN, 1'b0);
    wait_idle(SETTLE);

    // reset frame width: results only after a full row plus one
    gap_pct   = 15;
    stall_pct = 15;
    send_pixels(700, 50);
    for (int i = 0; i < 40; i++) send_item(OP_DRAIN, $urandom_range(0, 1));
    wait_idle(SETTLE);

    // 3x3 frame, dilation of a lone centre pixel
    write_reg(REG_MODE, MODE_DILATE);
    write_reg(REG_WIDTH, MIN_SIZE);
    write_reg(REG_HEIGHT, MIN_SIZE);
    for (int i = 0; i < 9; i++) send_item(OP_PIXEL, i == 4);
    wait_idle(SETTLE);
    // mode change with pixels pending, then erosion of a frame with one
    // border zero
    write_reg(REG_MODE, MODE_ERODE);
    for (int i = 0; i < 9; i++) send_item(OP_PIXEL, i != 0);
    for (int i = 0; i < 4; i++) send_item(OP_DRAIN, 1'b1);
    wait_idle(SETTLE);

    // random phases; the last stretch runs without idling
    k = 0;
    while (items_done < ITEMS_TARGET) begin
      if (items_done > ITEMS_TARGET * 7 / 8) calm = 1'b1;
      run_phase(k);
      k++;
    end

    wait_idle(SETTLE_END);
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("tb_binary_morphology_3x3_top: PASS");
    end else begin
      $display("tb_binary_morphology_3x3_top: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_binary_morphology_3x3_top: FAIL");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/bm3_pkg.sv
hw/rtl/bm3_ram.sv
hw/rtl/bm3_cfg.sv
hw/rtl/bm3_sched.sv
hw/rtl/bm3_window.sv
hw/rtl/binary_morphology_3x3_top.sv
tb/tb_binary_morphology_3x3_top.sv
